// ----- hw/rtl/pidcc_pkg.sv -----
package pidcc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CORR_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX = 3'd4;

  localparam logic signed [CFG_DATA_W-1:0] GAIN_P_RESET  = 32'sd78643;
  localparam logic signed [CFG_DATA_W-1:0] GAIN_I_RESET  = 32'sd66;
  localparam logic signed [CFG_DATA_W-1:0] GAIN_D_RESET  = 32'sd1966080;
  localparam logic signed [CFG_DATA_W-1:0] OUT_MIN_RESET = 32'sd0;
  localparam logic signed [CFG_DATA_W-1:0] OUT_MAX_RESET = 32'sd0;

  localparam logic signed [CORR_W-1:0] CORR_MAX = 32'sh7fffffff;
  localparam logic signed [CORR_W-1:0] CORR_MIN = 32'sh80000000;

endpackage

// ----- hw/rtl/pid_correction_clamped_core.sv -----
// Pipeline: an accepted error sample passes through four registers in turn
//   (state update, multiply, sum, scale/saturate/clamp) to the output.
// Throughput: one sample per cycle unless the output stalls; the four register
//   stages advance independently, so empty stages fill while the output waits.
// Reset: synchronous; gains and limits return to defaults, integral and
//   previous error clear, the next sample is treated as the first one.
module pid_correction_clamped_core
  import pidcc_pkg::*;
#(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // error_sample
  input  logic [((ERROR_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // correction
  output logic [CORR_W-1:0]                 m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int DIFF_W = ERROR_WIDTH + 1;
  localparam int P_W    = CFG_DATA_W + ERROR_WIDTH;
  localparam int I_W    = CFG_DATA_W + CORR_W;
  localparam int D_W    = CFG_DATA_W + DIFF_W;
  localparam int ACC_W  = ((D_W > I_W) ? D_W : I_W) + 2;
  localparam int SH_W   = ACC_W - GAIN_FRAC_BITS;

  logic signed [CFG_DATA_W-1:0] gain_p, gain_i, gain_d, out_min, out_max;

  logic                          first_sample;
  logic signed [ERROR_WIDTH-1:0] previous_error;
  logic signed [CORR_W-1:0]      error_sum;

  logic                          s1_valid, s2_valid, s3_valid;
  logic signed [ERROR_WIDTH-1:0] s1_err;
  logic signed [CORR_W-1:0]      s1_sum;
  logic signed [DIFF_W-1:0]      s1_diff;
  logic signed [P_W-1:0]         s2_p;
  logic signed [I_W-1:0]         s2_i;
  logic signed [D_W-1:0]         s2_d;
  logic signed [ACC_W-1:0]       s3_acc;

  logic out_ready, s3_ready, s2_ready, s1_ready, accept;

  logic signed [ERROR_WIDTH-1:0] err_in;
  logic signed [CORR_W:0]        sum_wide;
  logic signed [CORR_W-1:0]      sum_sat;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [SH_W-1:0]        scaled;
  logic signed [CORR_W-1:0]      sat;
  logic signed [CORR_W-1:0]      corr_next;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s3_ready      = !s3_valid || out_ready;
  assign s2_ready      = !s2_valid || s3_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s1_ready;

  always_comb begin
    err_in   = signed'(s_axis_tdata[ERROR_WIDTH-1:0]);
    sum_wide = (CORR_W+1)'(error_sum) + (CORR_W+1)'(err_in);
    if (sum_wide[CORR_W] != sum_wide[CORR_W-1]) begin
      sum_sat = sum_wide[CORR_W] ? CORR_MIN : CORR_MAX;
    end else begin
      sum_sat = sum_wide[CORR_W-1:0];
    end
    diff = DIFF_W'(err_in) - DIFF_W'(previous_error);
  end

  always_comb begin
    scaled = SH_W'(s3_acc >>> GAIN_FRAC_BITS);
    if (scaled > SH_W'(CORR_MAX)) begin
      sat = CORR_MAX;
    end else if (scaled < SH_W'(CORR_MIN)) begin
      sat = CORR_MIN;
    end else begin
      sat = scaled[CORR_W-1:0];
    end
    corr_next = sat;
    if (out_min != out_max) begin
      if (corr_next > out_max) begin
        corr_next = out_max;
      end
      if (corr_next < out_min) begin
        corr_next = out_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p  <= GAIN_P_RESET;
      gain_i  <= GAIN_I_RESET;
      gain_d  <= GAIN_D_RESET;
      out_min <= OUT_MIN_RESET;
      out_max <= OUT_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:  gain_p  <= signed'(cfg_data);
        REG_GAIN_I:  gain_i  <= signed'(cfg_data);
        REG_GAIN_D:  gain_d  <= signed'(cfg_data);
        REG_OUT_MIN: out_min <= signed'(cfg_data);
        REG_OUT_MAX: out_max <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample   <= 1'b1;
      previous_error <= '0;
      error_sum      <= '0;
    end else if (accept) begin
      first_sample   <= 1'b0;
      previous_error <= err_in;
      if (!first_sample) begin
        error_sum <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= s_axis_tvalid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (out_ready) m_axis_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err  <= err_in;
      s1_sum  <= first_sample ? '0 : sum_sat;
      s1_diff <= first_sample ? '0 : diff;
    end
    if (s2_ready && s1_valid) begin
      s2_p <= P_W'(gain_p) * P_W'(s1_err);
      s2_i <= I_W'(gain_i) * I_W'(s1_sum);
      s2_d <= D_W'(gain_d) * D_W'(s1_diff);
    end
    if (s3_ready && s2_valid) begin
      s3_acc <= ACC_W'(s2_p) + ACC_W'(s2_i) + ACC_W'(s2_d);
    end
    if (out_ready && s3_valid) begin
      m_axis_tdata <= corr_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_first_p_only: assert property (@(posedge clk) disable iff (rst)
    (accept && first_sample) |=> (s1_sum == '0 && s1_diff == '0))
    else $error("first sample carries integral or derivative operand");

  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    accept |=> !first_sample)
    else $error("first-sample flag not cleared after a transaction");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_err) && $stable(s1_sum)))
    else $error("stage one lost its operands while stalled");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_min < out_max) |->
      (signed'(m_axis_tdata) >= out_min && signed'(m_axis_tdata) <= out_max))
    else $error("correction outside clamp limits");
`endif

endmodule

// ----- tb/pid_correction_clamped_core_test.sv -----
`timescale 1ns / 100ps

module pid_correction_clamped_core_test
  import pidcc_pkg::*;
();

  localparam int ERR_W     = 16;
  localparam int FRAC_BITS = 16;
  localparam int LIMIT     = 1500000;

  class pid_scoreboard;
    logic signed [CFG_DATA_W-1:0] kp, ki, kd, lo_lim, hi_lim;
    bit primed;
    logic signed [ERR_W-1:0] last_err;
    logic signed [31:0] integral;
    logic signed [CORR_W-1:0] pending[$];
    int n_fail;

    function new();
      kp = GAIN_P_RESET;
      ki = GAIN_I_RESET;
      kd = GAIN_D_RESET;
      lo_lim = OUT_MIN_RESET;
      hi_lim = OUT_MAX_RESET;
      primed = 0;
      last_err = '0;
      integral = '0;
      n_fail = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GAIN_P:  kp = val;
        REG_GAIN_I:  ki = val;
        REG_GAIN_D:  kd = val;
        REG_OUT_MIN: lo_lim = val;
        REG_OUT_MAX: hi_lim = val;
        default: ;
      endcase
    endfunction

    // accepted error sample: advance the controller state, queue the correction
    function void note_error(logic signed [ERR_W-1:0] e);
      logic signed [95:0] wp, wi, wd, we, ws, wdiff, acc, sh, top, bot;
      longint s;
      logic signed [CORR_W-1:0] c;
      wp = kp;
      wi = ki;
      wd = kd;
      we = e;
      top = CORR_MAX;
      bot = CORR_MIN;
      if (!primed) begin
        acc = wp * we;
        primed = 1;
      end else begin
        s = longint'(integral) + longint'(e);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        integral = s[31:0];
        ws = integral;
        wdiff = we;
        wdiff = wdiff - 96'(last_err);
        acc = wp * we + wi * ws + wd * wdiff;
      end
      last_err = e;
      sh = acc >>> FRAC_BITS;
      if (sh > top) c = CORR_MAX;
      else if (sh < bot) c = CORR_MIN;
      else c = sh[CORR_W-1:0];
      if (lo_lim != hi_lim) begin
        if (c > hi_lim) c = hi_lim;
        if (c < lo_lim) c = lo_lim;
      end
      pending.push_back(c);
    endfunction

    function void check_correction(logic [CORR_W-1:0] got);
      logic signed [CORR_W-1:0] want;
      if (pending.size() == 0) begin
        n_fail++;
        $error("correction: none expected, got %0d", $signed(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        n_fail++;
        $error("correction: expected %0d, got %0d", want, $signed(got));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [ERR_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [CORR_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_scoreboard sb = new();
  bit fast_mode = 0;
  bit rx_hold_req = 0;
  bit rx_calm = 0;
  bit tx_calm = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;

  pid_correction_clamped_core #(
    .ERROR_WIDTH(ERR_W),
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("pid_correction_clamped_core_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
    if (rx_hold_req) begin
      hold_left = 400;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else if (fast_mode || rx_calm) begin
      m_axis_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_correction(m_axis_tdata);
  end

  function automatic int next_gap();
    int r;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (fast_mode || tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_error(logic signed [ERR_W-1:0] e);
    int gap;
    bit ok;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= e;
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_error(e);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // one write to an unused index, then all five registers
  task automatic load_regs(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                           logic [31:0] mn, logic [31:0] mx);
    write_reg(CFG_INDEX_W'(REG_OUT_MAX + $urandom_range(1, 3)), $urandom);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_OUT_MIN, mn);
    write_reg(REG_OUT_MAX, mx);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      5: return '0;
      default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    endcase
  endfunction

  task automatic random_setup();
    logic signed [31:0] a, b, t;
    a = $urandom;
    b = $urandom;
    if ($urandom_range(0, 1)) begin
      a = a >>> 12;
      b = b >>> 12;
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    case ($urandom_range(0, 4))
      0: load_regs(pick_gain(), pick_gain(), pick_gain(), a, a);
      1: load_regs(pick_gain(), pick_gain(), pick_gain(), a, b);
      2: load_regs(pick_gain(), pick_gain(), pick_gain(), b, a);
      3: load_regs(pick_gain(), pick_gain(), pick_gain(), CORR_MIN, CORR_MAX);
      default: load_regs(pick_gain(), pick_gain(), pick_gain(), CORR_MAX, CORR_MIN);
    endcase
  endtask

  function automatic logic [ERR_W-1:0] pick_error();
    case ($urandom_range(0, 9))
      5, 6, 7: return ERR_W'($urandom_range(0, 200)) - ERR_W'(100);
      8: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      9: return $urandom_range(0, 1) ? 16'h7fff - ERR_W'($urandom_range(0, 15))
                                     : 16'h8000 + ERR_W'($urandom_range(0, 15));
      default: return ERR_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // reset settings, clamp off; the first sample is proportional only
    send_error(16'h7fff);
    send_error(16'h8000);
    send_error(16'h0000);
    send_error(16'h0001);
    send_error(16'hffff);
    send_error(16'h5555);
    send_error(16'haaaa);
    send_error(16'h7fff);
    drain();

    // extreme gains, output saturates both ways
    load_regs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_error(16'h7fff);
    send_error(16'h8000);
    send_error(16'h8000);
    send_error(16'h7fff);
    send_error(16'h0000);
    drain();

    // reversed limits: lower limit wins
    load_regs(32'h0001_0000, '0, '0, 32'd100, -32'sd100);
    send_error(16'd50);
    send_error(16'd500);
    send_error(-16'sd500);
    drain();

    load_regs(32'h0001_0000, '0, '0, -32'sd1000, 32'sd2000);
    send_error(16'h8000);
    send_error(16'h7fff);
    send_error(16'd10);
    drain();

    // equal limits: no clamp
    load_regs(32'h0001_0000, 32'h0000_4000, 32'h0002_0000, 32'd1234, 32'd1234);
    send_error(16'd7);
    send_error(16'h8000);
    send_error(16'h7fff);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 20) rx_hold_req = 1;
        send_error(pick_error());
      end
      drain();
    end

    // back to back on both sides
    fast_mode = 1;
    repeat (30) send_error(pick_error());
    fast_mode = 0;

    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.n_fail == 0 && sb.pending.size() == 0)
      $display("pid_correction_clamped_core_test: done, clean");
    else
      $display("pid_correction_clamped_core_test: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pidcc_pkg.sv
hw/rtl/pid_correction_clamped_core.sv
tb/pid_correction_clamped_core_test.sv
